// ===== rtl/mcpg_pkg.sv =====
// Shared constants, codes and types of the midpoint circle point generator.
package mcpg_pkg;

  // Width of a centre coordinate and of the radius.
  localparam int COORD_BITS = 16;
  // Width of a plotted point coordinate: signed, room for centre plus radius.
  localparam int PT_BITS = COORD_BITS + 2;
  // Width of the signed decision value.
  localparam int DEC_BITS = COORD_BITS + 4;
  // Width of the signed difference terms.
  localparam int TERM_BITS = COORD_BITS + 2;
  // Width of the point index within one item's burst of points.
  localparam int IDX_BITS = 3;

  // Operation codes of an input item.
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Point indexes of the last point of a start burst and of a step burst.
  localparam logic [IDX_BITS-1:0] START_LAST_IDX = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] STEP_LAST_IDX  = IDX_BITS'(7);

  // One burst of points, handed from the step logic to the point emitter.
  typedef struct packed {
    logic                  start;
    logic                  done;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
  } job_t;

endpackage

// ===== rtl/mcpg_step.sv =====
// Circle state registers and the midpoint update for one input item.
module mcpg_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           operation,
  input  logic [mcpg_pkg::COORD_BITS-1:0] center_x,
  input  logic [mcpg_pkg::COORD_BITS-1:0] center_y,
  input  logic [mcpg_pkg::COORD_BITS-1:0] radius,
  output mcpg_pkg::job_t                 job,
  output logic                           job_valid,
  output logic                           active
);

  logic [mcpg_pkg::COORD_BITS-1:0] center_x_reg;
  logic [mcpg_pkg::COORD_BITS-1:0] center_y_reg;
  logic [mcpg_pkg::COORD_BITS-1:0] offset_x;
  logic [mcpg_pkg::COORD_BITS-1:0] offset_y;
  logic signed [mcpg_pkg::DEC_BITS-1:0]  decision;
  logic signed [mcpg_pkg::TERM_BITS-1:0] step_x_term;
  logic signed [mcpg_pkg::TERM_BITS-1:0] step_y_term;

  logic                                  active_next;
  logic [mcpg_pkg::COORD_BITS-1:0]       center_x_next;
  logic [mcpg_pkg::COORD_BITS-1:0]       center_y_next;
  logic [mcpg_pkg::COORD_BITS-1:0]       offset_x_next;
  logic [mcpg_pkg::COORD_BITS-1:0]       offset_y_next;
  logic signed [mcpg_pkg::DEC_BITS-1:0]  decision_next;
  logic signed [mcpg_pkg::TERM_BITS-1:0] step_x_next;
  logic signed [mcpg_pkg::TERM_BITS-1:0] step_y_next;

  logic signed [mcpg_pkg::DEC_BITS-1:0]  dec_mid;
  logic signed [mcpg_pkg::TERM_BITS-1:0] sy_mid;
  logic [mcpg_pkg::COORD_BITS-1:0]       oy_mid;
  logic                                  done;

  // Start loads a fresh circle; a step advances one octant step of the midpoint scheme.
  always_comb begin
    active_next   = active;
    center_x_next = center_x_reg;
    center_y_next = center_y_reg;
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    step_x_next   = step_x_term;
    step_y_next   = step_y_term;
    dec_mid       = decision;
    sy_mid        = step_y_term;
    oy_mid        = offset_y;
    done          = 1'b0;
    job_valid     = 1'b0;
    case (mcpg_pkg::op_t'(operation))
      mcpg_pkg::OP_START: begin
        center_x_next = center_x;
        center_y_next = center_y;
        offset_x_next = '0;
        offset_y_next = radius;
        decision_next = mcpg_pkg::DEC_BITS'(1)
                        - $signed({{(mcpg_pkg::DEC_BITS-mcpg_pkg::COORD_BITS){1'b0}}, radius});
        step_x_next   = '0;
        step_y_next   = -$signed({1'b0, radius, 1'b0});
        done          = (radius == '0);
        active_next   = !done;
        job_valid     = 1'b1;
      end
      mcpg_pkg::OP_STEP: begin
        if (active) begin
          // A non-negative decision moves the y offset inwards first.
          if (!decision[mcpg_pkg::DEC_BITS-1]) begin
            oy_mid  = offset_y - mcpg_pkg::COORD_BITS'(1);
            sy_mid  = step_y_term + mcpg_pkg::TERM_BITS'(2);
            dec_mid = decision + mcpg_pkg::DEC_BITS'(sy_mid);
          end
          offset_x_next = offset_x + mcpg_pkg::COORD_BITS'(1);
          offset_y_next = oy_mid;
          step_x_next   = step_x_term + mcpg_pkg::TERM_BITS'(2);
          step_y_next   = sy_mid;
          decision_next = dec_mid + mcpg_pkg::DEC_BITS'(step_x_next)
                          + mcpg_pkg::DEC_BITS'(1);
          done          = (offset_x_next >= offset_y_next);
          active_next   = !done;
          job_valid     = 1'b1;
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  // Burst description for the emitter.
  always_comb begin
    job.start = (operation == mcpg_pkg::OP_START);
    job.done  = done;
    job.cx    = center_x_next;
    job.cy    = center_y_next;
    job.ox    = offset_x_next;
    job.oy    = offset_y_next;
  end

  // Control state under reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      active <= active_next;
    end
  end

  // Circle state, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_reg <= '0;
      center_y_reg <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      decision     <= '0;
      step_x_term  <= '0;
      step_y_term  <= '0;
    end else if (take) begin
      center_x_reg <= center_x_next;
      center_y_reg <= center_y_next;
      offset_x     <= offset_x_next;
      offset_y     <= offset_y_next;
      decision     <= decision_next;
      step_x_term  <= step_x_next;
      step_y_term  <= step_y_next;
    end
  end

endmodule

// ===== rtl/mcpg_emit.sv =====
// Burst slot and emitter: one symmetric point per unstalled cycle into an output register.
module mcpg_emit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  mcpg_pkg::job_t                      job_in,
  input  logic                                job_in_valid,
  output logic                                take,
  output logic                                busy,
  output logic                                point_valid,
  input  logic                                point_stall,
  output logic signed [mcpg_pkg::PT_BITS-1:0] point_x,
  output logic signed [mcpg_pkg::PT_BITS-1:0] point_y,
  output logic                                last_point
);

  mcpg_pkg::job_t                   job;
  logic [mcpg_pkg::IDX_BITS-1:0]    idx;
  logic [mcpg_pkg::IDX_BITS-1:0]    last_idx;
  logic                             out_free;
  logic                             load;
  logic                             consume;
  logic                             slot_free;
  logic signed [mcpg_pkg::PT_BITS-1:0] ecx;
  logic signed [mcpg_pkg::PT_BITS-1:0] ecy;
  logic signed [mcpg_pkg::PT_BITS-1:0] ex;
  logic signed [mcpg_pkg::PT_BITS-1:0] ey;
  logic signed [mcpg_pkg::PT_BITS-1:0] px_next;
  logic signed [mcpg_pkg::PT_BITS-1:0] py_next;

  // Handshake control: the burst slot frees as its last point enters the output register.
  always_comb begin
    last_idx  = job.start ? mcpg_pkg::START_LAST_IDX : mcpg_pkg::STEP_LAST_IDX;
    out_free  = !point_valid || !point_stall;
    load      = busy && out_free;
    consume   = load && (idx == last_idx);
    slot_free = !busy || consume;
    take      = item_valid && slot_free;
  end

  // Zero-extended operands of the point arithmetic.
  always_comb begin
    ecx = $signed({2'b00, job.cx});
    ecy = $signed({2'b00, job.cy});
    ex  = $signed({2'b00, job.ox});
    ey  = $signed({2'b00, job.oy});
  end

  // Point selection: axis points on a start, the eight octant mirrors on a step.
  always_comb begin
    px_next = ecx;
    py_next = ecy;
    if (job.start) begin
      case (idx)
        3'd0:    begin px_next = ecx;      py_next = ecy + ey; end
        3'd1:    begin px_next = ecx;      py_next = ecy - ey; end
        3'd2:    begin px_next = ecx + ey; py_next = ecy;      end
        default: begin px_next = ecx - ey; py_next = ecy;      end
      endcase
    end else begin
      case (idx)
        3'd0:    begin px_next = ecx + ex; py_next = ecy + ey; end
        3'd1:    begin px_next = ecx - ex; py_next = ecy + ey; end
        3'd2:    begin px_next = ecx + ex; py_next = ecy - ey; end
        3'd3:    begin px_next = ecx - ex; py_next = ecy - ey; end
        3'd4:    begin px_next = ecx + ey; py_next = ecy + ex; end
        3'd5:    begin px_next = ecx - ey; py_next = ecy + ex; end
        3'd6:    begin px_next = ecx + ey; py_next = ecy - ex; end
        default: begin px_next = ecx - ey; py_next = ecy - ex; end
      endcase
    end
  end

  // Burst slot and point index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        busy <= job_in_valid;
        idx  <= '0;
      end else if (consume) begin
        busy <= 1'b0;
        idx  <= '0;
      end else if (load) begin
        idx <= idx + mcpg_pkg::IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_in;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (out_free) begin
      point_valid <= busy;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      point_x    <= px_next;
      point_y    <= py_next;
      last_point <= job.done && (idx == last_idx);
    end
  end

endmodule

// ===== rtl/midpoint_circle_point_generator.sv =====
// Top level of the midpoint circle point generator.
//
// Input channel (item_valid / item_stall) carries operation, center_x, center_y
// and radius. A start item emits the four axis points of the circle; each step
// item advances one octant step and emits the eight mirrored points. A step
// with no circle running is taken and emits nothing. last_point marks the
// final point of a circle, including the fourth point of a zero-radius start.
// Output channel (point_valid / point_stall) carries point_x, point_y and
// last_point, one point per transfer, in the order the points are generated.
// The first point of an item passes through the burst register, then the output register.
// Throughput: one point per cycle while the output is not stalled, from a single
// output register; a step item emits eight points and a start item four. The
// next item is taken in the cycle its predecessor's last point enters the
// output register, so there are no gaps between bursts.
// A stall on the output holds the output register and the point index, and
// item_stall stays high until the last point of the burst has entered the
// output register. Reset (synchronous, active high) clears the output valid,
// empties the burst slot and leaves no circle active.
module midpoint_circle_point_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                operation,
  input  logic [mcpg_pkg::COORD_BITS-1:0]     center_x,
  input  logic [mcpg_pkg::COORD_BITS-1:0]     center_y,
  input  logic [mcpg_pkg::COORD_BITS-1:0]     radius,
  output logic                                point_valid,
  input  logic                                point_stall,
  output logic signed [mcpg_pkg::PT_BITS-1:0] point_x,
  output logic signed [mcpg_pkg::PT_BITS-1:0] point_y,
  output logic                                last_point
);

  mcpg_pkg::job_t job;
  logic           job_valid;
  logic           take;
  logic           busy;
  logic           active;

  mcpg_step u_step (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (operation),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .job       (job),
    .job_valid (job_valid),
    .active    (active)
  );

  mcpg_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .job_in       (job),
    .job_in_valid (job_valid),
    .take         (take),
    .busy         (busy),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point)
  );

  // The input is held off only while a burst is still being emitted.
  assign item_stall = item_valid && !take;

  // A start transfer always leaves a burst pending.
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && operation == mcpg_pkg::OP_START) |=> busy)
    else $error("start transfer left no burst pending");

  // A step transfer with no circle running leaves the emitter empty.
  a_idle_step_empty: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && operation == mcpg_pkg::OP_STEP && !active) |=> !busy)
    else $error("step without circle produced a burst");

  // Stalling the input implies a burst is in progress.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> busy)
    else $error("input stalled with no burst pending");

  // A pending burst with a free output register always produces a point next cycle.
  a_burst_emits: assert property (@(posedge clk) disable iff (rst)
    (busy && (!point_valid || !point_stall)) |=> point_valid)
    else $error("pending burst failed to load the output register");

endmodule
